FILE: design/gjk2d_pkg.sv
package gjk2d_pkg;

   localparam int DEF_MAX_VERTICES = 16;
   localparam int DEF_MAX_STEPS    = 32;
   localparam int DEF_COORD_BITS   = 16;

   localparam logic [2:0] ACTION_CLEAR = 3'd0;
   localparam logic [2:0] ACTION_VERT_A = 3'd1;
   localparam logic [2:0] ACTION_VERT_B = 3'd2;
   localparam logic [2:0] ACTION_POS_A = 3'd3;
   localparam logic [2:0] ACTION_POS_B = 3'd4;
   localparam logic [2:0] ACTION_RUN = 3'd5;

   localparam logic [1:0] OUTCOME_NONE  = 2'd0;
   localparam logic [1:0] OUTCOME_FOUND = 2'd1;
   localparam logic [1:0] OUTCOME_LIMIT = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
   } req_type;

   typedef struct packed {
      logic [1:0] outcome;
      logic [5:0] iterations_used;
   } rsp_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CLEAR,
      ACT_LOAD_A,
      ACT_LOAD_B,
      ACT_POS_A,
      ACT_POS_B,
      ACT_RUN_INIT,
      ACT_DIR_POS,
      ACT_DIR_NEG,
      ACT_DIR_CROSS2,
      ACT_LATCH_SIGN,
      ACT_REDUCE_AB,
      ACT_REDUCE_AC,
      ACT_SCAN_INIT,
      ACT_STORE_SUP
   } dp_act_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CROSS2,
      OP_CROSS3,
      OP_ABP,
      OP_ACP,
      OP_FINAL
   } dp_op_type;

   typedef struct packed {
      dp_act_type act;
      dp_op_type  op;
      logic       rd_en;
      logic       rd_shape;
      logic       rd_first;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] size;
      logic       dot_pos;
   } dp_status_type;

endpackage

FILE: design/gjk2d_ram.sv
module gjk2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gjk2d_datapath.sv
module gjk2d_datapath import gjk2d_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  req_type                              req_data,
   input  dp_cmd_type                           dp_cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0]      rd_idx,
   output logic [$clog2(MAX_VERTICES+1)-1:0]    count_a,
   output logic [$clog2(MAX_VERTICES+1)-1:0]    count_b,
   output dp_status_type                        dp_status
);

   localparam int C    = COORD_BITS;
   localparam int PW   = C + 1;
   localparam int DW   = C + 2;
   localparam int PRW  = 2 * DW;
   localparam int SUMW = PRW + 1;
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int CW   = $clog2(MAX_VERTICES + 1);

   logic signed [C-1:0] in_x, in_y;
   assign in_x = C'(req_data.coord_x);
   assign in_y = C'(req_data.coord_y);

   logic [CW-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic signed [C-1:0] pos_ax_ff, pos_ax_in, pos_ay_ff, pos_ay_in;
   logic signed [C-1:0] pos_bx_ff, pos_bx_in, pos_by_ff, pos_by_in;
   logic signed [PW-1:0] sp_x_ff [3];
   logic signed [PW-1:0] sp_x_in [3];
   logic signed [PW-1:0] sp_y_ff [3];
   logic signed [PW-1:0] sp_y_in [3];
   logic [1:0] size_ff, size_in;
   logic signed [DW-1:0] dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic sgn_pos_ff, sgn_pos_in, sgn_neg_ff, sgn_neg_in;
   logic signed [C-1:0] best_ax_ff, best_ax_in, best_ay_ff, best_ay_in;
   logic signed [C-1:0] best_bx_ff, best_bx_in, best_by_ff, best_by_in;
   logic signed [SUMW-1:0] best_dot_ff, best_dot_in;
   logic s1_valid_ff, s1_shape_ff, s1_first_ff;
   logic s2_valid_ff, s2_shape_ff, s2_first_ff;
   logic signed [C-1:0] vert_x_ff, vert_y_ff;
   logic signed [PRW-1:0] prod_x_ff, prod_y_ff;

   // vertex stores
   logic wr_a, wr_b;
   logic [2*C-1:0] rd_a, rd_b;
   assign wr_a = (dp_cmd.act == ACT_LOAD_A) && (count_a_ff < CW'(MAX_VERTICES));
   assign wr_b = (dp_cmd.act == ACT_LOAD_B) && (count_b_ff < CW'(MAX_VERTICES));

   gjk2d_ram #(.WIDTH(2 * C), .DEPTH(MAX_VERTICES)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (count_a_ff[AW-1:0]),
      .wr_data ({in_x, in_y}),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_a)
   );

   gjk2d_ram #(.WIDTH(2 * C), .DEPTH(MAX_VERTICES)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (count_b_ff[AW-1:0]),
      .wr_data ({in_x, in_y}),
      .rd_en   (dp_cmd.rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_b)
   );

   logic signed [C-1:0] vx, vy;
   assign vx = s1_shape_ff ? $signed(rd_b[2*C-1:C]) : $signed(rd_a[2*C-1:C]);
   assign vy = s1_shape_ff ? $signed(rd_b[C-1:0]) : $signed(rd_a[C-1:0]);

   // simplex edge vectors
   logic signed [DW-1:0] cb_x, cb_y, ab_x, ab_y, ac_x, ac_y;
   logic signed [DW-1:0] abp_x, abp_y, acp_x, acp_y;
   logic signed [PW-1:0] sup_x, sup_y;
   assign cb_x = DW'(sp_x_ff[1]) - DW'(sp_x_ff[0]);
   assign cb_y = DW'(sp_y_ff[1]) - DW'(sp_y_ff[0]);
   assign ab_x = DW'(sp_x_ff[1]) - DW'(sp_x_ff[2]);
   assign ab_y = DW'(sp_y_ff[1]) - DW'(sp_y_ff[2]);
   assign ac_x = DW'(sp_x_ff[0]) - DW'(sp_x_ff[2]);
   assign ac_y = DW'(sp_y_ff[0]) - DW'(sp_y_ff[2]);
   assign abp_x = sgn_pos_ff ? -ab_y : (sgn_neg_ff ? ab_y : '0);
   assign abp_y = sgn_pos_ff ? ab_x : (sgn_neg_ff ? -ab_x : '0);
   assign acp_x = sgn_pos_ff ? ac_y : (sgn_neg_ff ? -ac_y : '0);
   assign acp_y = sgn_pos_ff ? -ac_x : (sgn_neg_ff ? ac_x : '0);
   assign sup_x = PW'(best_ax_ff) - PW'(best_bx_ff);
   assign sup_y = PW'(best_ay_ff) - PW'(best_by_ff);

   // dot product unit operands
   logic signed [DW-1:0] opa_x, opa_y, opb_x, opb_y;
   always_comb begin
      opa_x = '0;
      opa_y = '0;
      opb_x = '0;
      opb_y = '0;
      if (s1_valid_ff) begin
         opa_x = dir_x_ff;
         opa_y = dir_y_ff;
         opb_x = DW'(vx);
         opb_y = DW'(vy);
      end else begin
         case (dp_cmd.op)
            OP_CROSS2: begin
               opa_x = cb_x;
               opa_y = cb_y;
               opb_x = -DW'(sp_y_ff[0]);
               opb_y = DW'(sp_x_ff[0]);
            end
            OP_CROSS3: begin
               opa_x = ac_x;
               opa_y = ac_y;
               opb_x = ab_y;
               opb_y = -ab_x;
            end
            OP_ABP: begin
               opa_x = abp_x;
               opa_y = abp_y;
               opb_x = -DW'(sp_x_ff[2]);
               opb_y = -DW'(sp_y_ff[2]);
            end
            OP_ACP: begin
               opa_x = acp_x;
               opa_y = acp_y;
               opb_x = -DW'(sp_x_ff[2]);
               opb_y = -DW'(sp_y_ff[2]);
            end
            OP_FINAL: begin
               opa_x = dir_x_ff;
               opa_y = dir_y_ff;
               opb_x = DW'(sup_x);
               opb_y = DW'(sup_y);
            end
            default: begin
               opa_x = '0;
            end
         endcase
      end
   end

   logic signed [SUMW-1:0] dot_sum;
   assign dot_sum = SUMW'(prod_x_ff) + SUMW'(prod_y_ff);

   always_comb begin
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      pos_ax_in   = pos_ax_ff;
      pos_ay_in   = pos_ay_ff;
      pos_bx_in   = pos_bx_ff;
      pos_by_in   = pos_by_ff;
      sp_x_in     = sp_x_ff;
      sp_y_in     = sp_y_ff;
      size_in     = size_ff;
      dir_x_in    = dir_x_ff;
      dir_y_in    = dir_y_ff;
      sgn_pos_in  = sgn_pos_ff;
      sgn_neg_in  = sgn_neg_ff;
      best_ax_in  = best_ax_ff;
      best_ay_in  = best_ay_ff;
      best_bx_in  = best_bx_ff;
      best_by_in  = best_by_ff;
      best_dot_in = best_dot_ff;
      // farthest vertex along the direction for A, against it for B
      if (s2_valid_ff) begin
         if (!s2_shape_ff) begin
            if (s2_first_ff || (dot_sum > best_dot_ff)) begin
               best_dot_in = dot_sum;
               best_ax_in  = vert_x_ff;
               best_ay_in  = vert_y_ff;
            end
         end else begin
            if (s2_first_ff || (dot_sum < best_dot_ff)) begin
               best_dot_in = dot_sum;
               best_bx_in  = vert_x_ff;
               best_by_in  = vert_y_ff;
            end
         end
      end
      case (dp_cmd.act)
         ACT_CLEAR: begin
            count_a_in = '0;
            count_b_in = '0;
         end
         ACT_LOAD_A: begin
            if (wr_a) begin
               count_a_in = count_a_ff + 1'b1;
            end
         end
         ACT_LOAD_B: begin
            if (wr_b) begin
               count_b_in = count_b_ff + 1'b1;
            end
         end
         ACT_POS_A: begin
            pos_ax_in = in_x;
            pos_ay_in = in_y;
         end
         ACT_POS_B: begin
            pos_bx_in = in_x;
            pos_by_in = in_y;
         end
         ACT_RUN_INIT: begin
            size_in = 2'd0;
         end
         ACT_DIR_POS: begin
            dir_x_in = DW'(pos_bx_ff) - DW'(pos_ax_ff);
            dir_y_in = DW'(pos_by_ff) - DW'(pos_ay_ff);
         end
         ACT_DIR_NEG: begin
            dir_x_in = -dir_x_ff;
            dir_y_in = -dir_y_ff;
         end
         ACT_DIR_CROSS2: begin
            if (dot_sum > 0) begin
               dir_x_in = -cb_y;
               dir_y_in = cb_x;
            end else if (dot_sum < 0) begin
               dir_x_in = cb_y;
               dir_y_in = -cb_x;
            end else begin
               dir_x_in = '0;
               dir_y_in = '0;
            end
         end
         ACT_LATCH_SIGN: begin
            sgn_pos_in = dot_sum > 0;
            sgn_neg_in = dot_sum < 0;
         end
         ACT_REDUCE_AB: begin
            sp_x_in[0] = sp_x_ff[1];
            sp_y_in[0] = sp_y_ff[1];
            sp_x_in[1] = sp_x_ff[2];
            sp_y_in[1] = sp_y_ff[2];
            dir_x_in   = abp_x;
            dir_y_in   = abp_y;
            size_in    = 2'd2;
         end
         ACT_REDUCE_AC: begin
            sp_x_in[1] = sp_x_ff[2];
            sp_y_in[1] = sp_y_ff[2];
            dir_x_in   = acp_x;
            dir_y_in   = acp_y;
            size_in    = 2'd2;
         end
         ACT_SCAN_INIT: begin
            best_ax_in = '0;
            best_ay_in = '0;
            best_bx_in = '0;
            best_by_in = '0;
         end
         ACT_STORE_SUP: begin
            if (size_ff != 2'd3) begin
               sp_x_in[size_ff] = sup_x;
               sp_y_in[size_ff] = sup_y;
               size_in = size_ff + 2'd1;
            end
         end
         default: begin
            size_in = size_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         pos_ax_ff   <= '0;
         pos_ay_ff   <= '0;
         pos_bx_ff   <= '0;
         pos_by_ff   <= '0;
         size_ff     <= '0;
         dir_x_ff    <= '0;
         dir_y_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         pos_ax_ff   <= pos_ax_in;
         pos_ay_ff   <= pos_ay_in;
         pos_bx_ff   <= pos_bx_in;
         pos_by_ff   <= pos_by_in;
         size_ff     <= size_in;
         dir_x_ff    <= dir_x_in;
         dir_y_ff    <= dir_y_in;
         s1_valid_ff <= dp_cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
      end
      sp_x_ff     <= sp_x_in;
      sp_y_ff     <= sp_y_in;
      sgn_pos_ff  <= sgn_pos_in;
      sgn_neg_ff  <= sgn_neg_in;
      best_ax_ff  <= best_ax_in;
      best_ay_ff  <= best_ay_in;
      best_bx_ff  <= best_bx_in;
      best_by_ff  <= best_by_in;
      best_dot_ff <= best_dot_in;
      s1_shape_ff <= dp_cmd.rd_shape;
      s1_first_ff <= dp_cmd.rd_first;
      s2_shape_ff <= s1_shape_ff;
      s2_first_ff <= s1_first_ff;
      vert_x_ff   <= vx;
      vert_y_ff   <= vy;
      prod_x_ff   <= PRW'(opa_x) * PRW'(opb_x);
      prod_y_ff   <= PRW'(opa_y) * PRW'(opb_y);
   end

   assign count_a = count_a_ff;
   assign count_b = count_b_ff;
   assign dp_status.size    = size_ff;
   assign dp_status.dot_pos = dot_sum > 0;

`ifndef SYNTHESIS
   a_store_grows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.act == ACT_STORE_SUP |=> size_ff != 2'd0)
      else $error("simplex empty after support store");
`endif

endmodule

FILE: design/gjk2d_ctrl.sv
module gjk2d_ctrl import gjk2d_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_STEPS    = DEF_MAX_STEPS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  req_type                           req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rsp_type                           rsp_data,
   output dp_cmd_type                        dp_cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]   rd_idx,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] count_a,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] count_b,
   input  dp_status_type                     dp_status
);

   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int SBW = $clog2(MAX_STEPS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_EVOLVE,
      ST_CROSS2_RES,
      ST_CROSS3_RES,
      ST_ABP_ISSUE,
      ST_ABP_RES,
      ST_ACP_RES,
      ST_SCAN_INIT,
      ST_SCAN_A,
      ST_SCAN_B,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_SUPPORT,
      ST_FINAL_RES,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [SBW-1:0] step_ff, step_in;
   logic [1:0]     outcome_ff, outcome_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;
   logic           req_accept;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      dp_cmd       = '{act: ACT_NONE, op: OP_NONE, rd_en: 1'b0, rd_shape: 1'b0,
                       rd_first: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.action)
                  ACTION_CLEAR:  dp_cmd.act = ACT_CLEAR;
                  ACTION_VERT_A: dp_cmd.act = ACT_LOAD_A;
                  ACTION_VERT_B: dp_cmd.act = ACT_LOAD_B;
                  ACTION_POS_A:  dp_cmd.act = ACT_POS_A;
                  ACTION_POS_B:  dp_cmd.act = ACT_POS_B;
                  ACTION_RUN:    state_in = ST_START;
                  default:       dp_cmd.act = ACT_NONE;
               endcase
            end
         end
         ST_START: begin
            dp_cmd.act = ACT_RUN_INIT;
            step_in    = '0;
            state_in   = ST_EVOLVE;
         end
         ST_EVOLVE: begin
            case (dp_status.size)
               2'd0: begin
                  dp_cmd.act = ACT_DIR_POS;
                  state_in   = ST_SCAN_INIT;
               end
               2'd1: begin
                  dp_cmd.act = ACT_DIR_NEG;
                  state_in   = ST_SCAN_INIT;
               end
               2'd2: begin
                  dp_cmd.op = OP_CROSS2;
                  state_in  = ST_CROSS2_RES;
               end
               default: begin
                  dp_cmd.op = OP_CROSS3;
                  state_in  = ST_CROSS3_RES;
               end
            endcase
         end
         ST_CROSS2_RES: begin
            dp_cmd.act = ACT_DIR_CROSS2;
            state_in   = ST_SCAN_INIT;
         end
         ST_CROSS3_RES: begin
            dp_cmd.act = ACT_LATCH_SIGN;
            state_in   = ST_ABP_ISSUE;
         end
         ST_ABP_ISSUE: begin
            dp_cmd.op = OP_ABP;
            state_in  = ST_ABP_RES;
         end
         ST_ABP_RES: begin
            if (dp_status.dot_pos) begin
               dp_cmd.act = ACT_REDUCE_AB;
               state_in   = ST_SCAN_INIT;
            end else begin
               dp_cmd.op = OP_ACP;
               state_in  = ST_ACP_RES;
            end
         end
         ST_ACP_RES: begin
            if (dp_status.dot_pos) begin
               dp_cmd.act = ACT_REDUCE_AC;
               state_in   = ST_SCAN_INIT;
            end else begin
               // origin enclosed by the triangle
               step_in    = step_ff + 1'b1;
               outcome_in = OUTCOME_FOUND;
               state_in   = ST_FINISH;
            end
         end
         ST_SCAN_INIT: begin
            dp_cmd.act = ACT_SCAN_INIT;
            idx_in     = '0;
            state_in   = ST_SCAN_A;
         end
         ST_SCAN_A: begin
            if (idx_ff < count_a) begin
               dp_cmd.rd_en    = 1'b1;
               dp_cmd.rd_first = idx_ff == '0;
               idx_in          = idx_ff + 1'b1;
            end else begin
               idx_in   = '0;
               state_in = ST_SCAN_B;
            end
         end
         ST_SCAN_B: begin
            if (idx_ff < count_b) begin
               dp_cmd.rd_en    = 1'b1;
               dp_cmd.rd_shape = 1'b1;
               dp_cmd.rd_first = idx_ff == '0;
               idx_in          = idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_SUPPORT;
         end
         ST_SUPPORT: begin
            dp_cmd.op  = OP_FINAL;
            dp_cmd.act = ACT_STORE_SUP;
            state_in   = ST_FINAL_RES;
         end
         ST_FINAL_RES: begin
            step_in = step_ff + 1'b1;
            if (!dp_status.dot_pos) begin
               outcome_in = OUTCOME_NONE;
               state_in   = ST_FINISH;
            end else if (step_in < SBW'(MAX_STEPS)) begin
               state_in = ST_EVOLVE;
            end else begin
               outcome_in = OUTCOME_LIMIT;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.outcome         = outcome_ff;
               rsp_data_in.iterations_used = 6'(step_ff);
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
      end
      outcome_ff  <= outcome_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rd_idx    = idx_ff[AW-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result beat raised outside finish");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= SBW'(MAX_STEPS))
      else $error("step count beyond limit");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rd_en |-> (dp_cmd.rd_shape ? (idx_ff < count_b) : (idx_ff < count_a)))
      else $error("vertex read beyond loaded count");
`endif

endmodule

FILE: design/gjk_intersection_test_2d.sv
// 2D GJK intersection test. Load beats (clear, vertex of A or B, position of A or B)
// are taken one per cycle while no run is in progress and give no result; action codes
// 6 and 7 are dropped. A run beat stalls the input until its single result (outcome,
// iterations used) is placed in the output register. A run takes up to MAX_STEPS steps;
// in each step one shared dot-product unit sweeps both vertex memories one vertex per
// cycle. Vertices beyond MAX_VERTICES per shape are dropped. Coordinates are signed Q8.8.
module gjk_intersection_test_2d import gjk2d_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_STEPS    = DEF_MAX_STEPS,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic [AW-1:0] rd_idx;
   logic [CW-1:0] count_a, count_b;

   gjk2d_ctrl #(.MAX_VERTICES(MAX_VERTICES), .MAX_STEPS(MAX_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .dp_cmd    (dp_cmd),
      .rd_idx    (rd_idx),
      .count_a   (count_a),
      .count_b   (count_b),
      .dp_status (dp_status)
   );

   gjk2d_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .rd_idx    (rd_idx),
      .count_a   (count_a),
      .count_b   (count_b),
      .dp_status (dp_status)
   );

endmodule

FILE: bench/tb_gjk_intersection_test_2d.sv
`timescale 1ns / 100ps

module tb_gjk_intersection_test_2d;
   import gjk2d_pkg::*;

   localparam int NVERT = DEF_MAX_VERTICES;
   localparam int NSTEP = DEF_MAX_STEPS;
   localparam int CYCLE_LIMIT = 2000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   gjk_intersection_test_2d u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // predictor state
   longint poly_a_x[NVERT], poly_a_y[NVERT], poly_b_x[NVERT], poly_b_y[NVERT];
   int     num_a, num_b;
   longint pos_a_x, pos_a_y, pos_b_x, pos_b_y;
   longint spx[3], spy[3];
   int     ssize;
   longint dir_x, dir_y;

   rsp_type outcome_q[$];
   int      mismatches;
   int      cycles;
   bit      done_stim;

   function automatic longint sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   // Minkowski support point along (dx,dy), ties to the first vertex
   task automatic support_point(input longint dx, input longint dy,
                                output longint sx, output longint sy);
      longint ax, ay, bx, by, best, d;
      ax = 0; ay = 0; bx = 0; by = 0;
      if (num_a > 0) begin
         ax = poly_a_x[0]; ay = poly_a_y[0]; best = dx*ax + dy*ay;
         for (int i = 1; i < num_a; i++) begin
            d = dx*poly_a_x[i] + dy*poly_a_y[i];
            if (d > best) begin
               best = d; ax = poly_a_x[i]; ay = poly_a_y[i];
            end
         end
      end
      if (num_b > 0) begin
         bx = poly_b_x[0]; by = poly_b_y[0]; best = dx*bx + dy*by;
         for (int i = 1; i < num_b; i++) begin
            d = dx*poly_b_x[i] + dy*poly_b_y[i];
            if (d < best) begin
               best = d; bx = poly_b_x[i]; by = poly_b_y[i];
            end
         end
      end
      sx = ax - bx; sy = ay - by;
   endtask

   // one simplex step: 0 going, 1 found, 2 none
   task automatic simplex_step(output int res);
      longint cx, cy, ex, ey, s, px, py, abx, aby, acx, acy, abpx, abpy, acpx, acpy;
      longint sx, sy;
      res = 0;
      if (ssize == 0) begin
         dir_x = pos_b_x - pos_a_x; dir_y = pos_b_y - pos_a_y;
      end else if (ssize == 1) begin
         dir_x = -dir_x; dir_y = -dir_y;
      end else if (ssize == 2) begin
         cx = spx[0]; cy = spy[0];
         ex = spx[1] - cx; ey = spy[1] - cy;
         s = sgn(ex*(-cy) - ey*(-cx));
         dir_x = -s*ey; dir_y = s*ex;
      end else begin
         px = spx[2]; py = spy[2];
         abx = spx[1] - px; aby = spy[1] - py;
         acx = spx[0] - px; acy = spy[0] - py;
         s = sgn(acx*aby - acy*abx);
         abpx = -s*aby; abpy = s*abx;
         s = sgn(abx*acy - aby*acx);
         acpx = -s*acy; acpy = s*acx;
         if (abpx*(-px) + abpy*(-py) > 0) begin
            spx[0] = spx[1]; spy[0] = spy[1];
            spx[1] = spx[2]; spy[1] = spy[2];
            dir_x = abpx; dir_y = abpy;
         end else if (acpx*(-px) + acpy*(-py) > 0) begin
            spx[1] = spx[2]; spy[1] = spy[2];
            dir_x = acpx; dir_y = acpy;
         end else begin
            res = 1;
            return;
         end
         ssize = 2;
      end
      support_point(dir_x, dir_y, sx, sy);
      if (ssize < 3) begin
         spx[ssize] = sx; spy[ssize] = sy; ssize++;
      end
      res = (dir_x*sx + dir_y*sy > 0) ? 0 : 2;
   endtask

   task automatic predict_beat(input req_type r);
      longint x, y;
      int res, steps;
      rsp_type o;
      x = longint'(r.coord_x); y = longint'(r.coord_y);
      case (r.action)
         ACTION_CLEAR: begin
            num_a = 0; num_b = 0;
         end
         ACTION_VERT_A: if (num_a < NVERT) begin
            poly_a_x[num_a] = x; poly_a_y[num_a] = y; num_a++;
         end
         ACTION_VERT_B: if (num_b < NVERT) begin
            poly_b_x[num_b] = x; poly_b_y[num_b] = y; num_b++;
         end
         ACTION_POS_A: begin
            pos_a_x = x; pos_a_y = y;
         end
         ACTION_POS_B: begin
            pos_b_x = x; pos_b_y = y;
         end
         ACTION_RUN: begin
            ssize = 0; steps = 0; res = 0;
            while (steps < NSTEP) begin
               simplex_step(res);
               steps++;
               if (res != 0) break;
            end
            o.outcome = (res == 1) ? OUTCOME_FOUND :
                        ((res == 2) ? OUTCOME_NONE : OUTCOME_LIMIT);
            o.iterations_used = 6'(steps);
            outcome_q.insert(outcome_q.size(), o);
         end
         default: ;
      endcase
   endtask

   // response checking and receiver stall pattern
   logic [6:0] stall_lfsr;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            if (rsp_data.outcome !== outcome_q[0].outcome ||
                rsp_data.iterations_used !== outcome_q[0].iterations_used) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p got %p", outcome_q[0], rsp_data);
            end
            void'(outcome_q.pop_front());
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(negedge clock) begin
      stall_lfsr <= {stall_lfsr[5:0], stall_lfsr[6] ^ stall_lfsr[5]};
      // periodic quiet stretches with no receiver stall
      if (reset || (cycles % 512) > 400) rsp_stall <= 1'b0;
      else rsp_stall <= (stall_lfsr[2:0] == 3'b000) || (stall_lfsr[6:5] == 2'b11);
   end

   int gap_left, burst_left;

   // drive one beat and hold it until taken; valid stays up until the next beat or gap
   task automatic send_beat(input req_type r);
      while (burst_left == 0) begin
         if (gap_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         end else begin
            req_valid <= 1'b0;
            gap_left--;
            @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(r);
      @(negedge clock);
   endtask

   function automatic req_type beat(input logic [2:0] act, input int x, input int y);
      req_type r;
      r.action = act; r.coord_x = 16'(x); r.coord_y = 16'(y);
      return r;
   endfunction

   function automatic int rand_coord(input int span);
      return $urandom_range(0, 2*span) - span;
   endfunction

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } stim_row;

   stim_row directed[$];
   req_type tmp;
   int runs;

   task automatic add_row(input req_type r, input bit typed, input logic [1:0] oc,
                          input int it);
      stim_row s;
      s.r = r; s.typed = typed; s.want.outcome = oc; s.want.iterations_used = 6'(it);
      directed.insert(directed.size(), s);
   endtask

   initial begin
      reset = 1'b1; req_valid = 1'b0; req_data = '0; rsp_stall = 1'b0;
      stall_lfsr = 7'h5a; cycles = 0; mismatches = 0; done_stim = 0;
      gap_left = 0; burst_left = 0;
      num_a = 0; num_b = 0; pos_a_x = 0; pos_a_y = 0; pos_b_x = 0; pos_b_y = 0;
      ssize = 0; dir_x = 0; dir_y = 0;

      // after reset: empty shapes, zero direction -> no intersection after one step
      add_row(beat(ACTION_RUN, 0, 0), 1, OUTCOME_NONE, 1);
      add_row(beat(3'd6, -1, -1), 0, 0, 0);
      add_row(beat(3'd7, 32767, -32768), 0, 0, 0);
      add_row(beat(ACTION_VERT_A, 32767, 32767), 0, 0, 0);
      add_row(beat(ACTION_VERT_A, -32768, -32768), 0, 0, 0);
      add_row(beat(ACTION_VERT_A, 32767, -32768), 0, 0, 0);
      add_row(beat(ACTION_VERT_B, -32768, 32767), 0, 0, 0);
      add_row(beat(ACTION_VERT_B, 0, 0), 0, 0, 0);
      add_row(beat(ACTION_VERT_B, 256, -256), 0, 0, 0);
      // coincident positions: zero direction
      add_row(beat(ACTION_RUN, 0, 0), 1, OUTCOME_NONE, 1);
      add_row(beat(ACTION_POS_A, -32768, -32768), 0, 0, 0);
      add_row(beat(ACTION_POS_B, 32767, 32767), 0, 0, 0);
      add_row(beat(ACTION_RUN, 0, 0), 0, 0, 0);
      add_row(beat(ACTION_CLEAR, 0, 0), 0, 0, 0);
      add_row(beat(ACTION_RUN, 0, 0), 0, 0, 0);
      // overlapping square and triangle
      add_row(beat(ACTION_VERT_A, -512, -512), 0, 0, 0);
      add_row(beat(ACTION_VERT_A, 512, -512), 0, 0, 0);
      add_row(beat(ACTION_VERT_A, 512, 512), 0, 0, 0);
      add_row(beat(ACTION_VERT_A, -512, 512), 0, 0, 0);
      add_row(beat(ACTION_VERT_B, -256, -256), 0, 0, 0);
      add_row(beat(ACTION_VERT_B, 256, -256), 0, 0, 0);
      add_row(beat(ACTION_VERT_B, 0, 256), 0, 0, 0);
      add_row(beat(ACTION_POS_A, 0, 0), 0, 0, 0);
      add_row(beat(ACTION_POS_B, 100, 30), 0, 0, 0);
      add_row(beat(ACTION_RUN, 0, 0), 0, 0, 0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         send_beat(directed[i].r);
         if (directed[i].typed && outcome_q.size() > 0 &&
             outcome_q[$] != directed[i].want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: table %p predictor %p",
                        i, directed[i].want, outcome_q[$]);
         end
      end

      // random scenes: usually clear, load both shapes, place them, run; some noise
      runs = 0;
      while (runs < 180) begin
         int na, nb, span, ca, cb;
         span = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(64, 2048);
         if ($urandom_range(0, 9) != 0) send_beat(beat(ACTION_CLEAR, 0, 0));
         na = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
         nb = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
         ca = rand_coord(span); cb = rand_coord(span);
         for (int k = 0; k < na; k++)
            send_beat(beat(ACTION_VERT_A, rand_coord(span), rand_coord(span)));
         for (int k = 0; k < nb; k++)
            send_beat(beat(ACTION_VERT_B, rand_coord(span), rand_coord(span)));
         send_beat(beat(ACTION_POS_A, ca, cb));
         send_beat(beat(ACTION_POS_B, rand_coord(span), rand_coord(span)));
         if ($urandom_range(0, 5) == 0) begin
            tmp = beat(3'($urandom_range(6, 7)), int'($urandom), int'($urandom));
            send_beat(tmp);
         end
         send_beat(beat(ACTION_RUN, int'($urandom), int'($urandom)));
         runs++;
         if ($urandom_range(0, 3) == 0) begin
            send_beat(beat(ACTION_POS_B, int'($urandom), int'($urandom)));
            send_beat(beat(ACTION_RUN, 0, 0));
            runs++;
         end
      end
      req_valid <= 1'b0;

      while (outcome_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/gjk2d_pkg.sv
design/gjk2d_ram.sv
design/gjk2d_datapath.sv
design/gjk2d_ctrl.sv
design/gjk_intersection_test_2d.sv
bench/tb_gjk_intersection_test_2d.sv
